// ===== hw/rtl/cam_pkg.sv =====
// Shared types, constants and the arctangent table for the camera update block.
package cam_pkg;

  // Angles are Q16.16 degrees.
  localparam logic signed [32:0] DEG          = 33'sd65536;
  localparam logic signed [32:0] QUARTER_TURN = 33'sd5898240;
  localparam logic signed [32:0] HALF_TURN    = 33'sd11796480;
  localparam logic signed [32:0] PITCH_LIMIT  = 33'sd5832704;

  // Yaw wrap: bias that makes any updated yaw positive before the reduction.
  localparam int MODW = 36;
  localparam logic signed [MODW-1:0] YAW_BIAS = 36'sd3031695360;
  // One full turn shifted up by the number of reduction steps minus one.
  localparam logic [MODW-1:0] MOD_TOP = 36'd3019898880;
  localparam int MOD_STEPS = 8;

  // Unit vectors are Q2.14.
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // CORDIC datapath.
  localparam int CORD_W = 34;
  localparam int ZW = 26;
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Serial multiplier: operand width, product width and digit size.
  localparam int MUL_W = 34;
  localparam int PROD_W = 68;
  localparam int MUL_DIGIT = 4;

  // Bit-serial square root and divider.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 16;
  localparam int DVW = 50;
  localparam int CNT_W = 5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_START_Z  = 3'd2,
    REG_BASE_SPD = 3'd3,
    REG_LOOK_SNS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_W-1:0]  a;
    logic signed [MUL_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [CORD_W-1:0] cos_v;
    logic signed [CORD_W-1:0] sin_v;
  } cor_rsp_t;

  // atan(2^-i) in Q16.16 degrees.
  function automatic logic [23:0] atan_deg(input logic [4:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:    v = 24'd2949120;
      5'd1:    v = 24'd1740967;
      5'd2:    v = 24'd919879;
      5'd3:    v = 24'd466945;
      5'd4:    v = 24'd234379;
      5'd5:    v = 24'd117304;
      5'd6:    v = 24'd58666;
      5'd7:    v = 24'd29335;
      5'd8:    v = 24'd14668;
      5'd9:    v = 24'd7334;
      5'd10:   v = 24'd3667;
      5'd11:   v = 24'd1833;
      5'd12:   v = 24'd917;
      5'd13:   v = 24'd458;
      5'd14:   v = 24'd229;
      5'd15:   v = 24'd115;
      5'd16:   v = 24'd57;
      5'd17:   v = 24'd29;
      5'd18:   v = 24'd14;
      5'd19:   v = 24'd7;
      5'd20:   v = 24'd4;
      5'd21:   v = 24'd2;
      5'd22:   v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/cam_mul.sv =====
// Digit-serial signed multiplier, four bits of the second operand per cycle.
module cam_mul (
  input  logic               clk,
  input  logic               rst,
  input  cam_pkg::mul_req_t  req,
  output cam_pkg::mul_rsp_t  rsp
);
  import cam_pkg::*;

  localparam int NDIG = (MUL_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BPAD = NDIG * MUL_DIGIT;
  localparam int CW = $clog2(NDIG);

  logic                busy;
  logic                done;
  logic [CW-1:0]       cnt;
  logic [MUL_W-1:0]    am;
  logic [BPAD-1:0]     bm;
  logic [PROD_W-1:0]   acc;
  logic                neg;

  logic [MUL_W-1:0]          a_mag;
  logic [MUL_W-1:0]          b_mag;
  logic [MUL_DIGIT-1:0]      dig;
  logic [MUL_W+MUL_DIGIT-1:0] partial;
  logic [PROD_W-1:0]         acc_next;

  // Magnitudes of the operands and one digit step, most significant first.
  always_comb begin
    a_mag    = req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
    b_mag    = req.b[MUL_W-1] ? MUL_W'(-req.b) : MUL_W'(req.b);
    dig      = bm[BPAD-1 -: MUL_DIGIT];
    partial  = am * dig;
    acc_next = (acc << MUL_DIGIT) + PROD_W'(partial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        am   <= a_mag;
        bm   <= BPAD'(b_mag);
        acc  <= '0;
        neg  <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        bm  <= bm << MUL_DIGIT;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NDIG - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign is applied on the way out.
  always_comb begin
    rsp.done = done;
    rsp.prod = neg ? -$signed(acc) : $signed(acc);
  end

endmodule

// ===== hw/rtl/cam_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a Q16.16 degree angle.
module cam_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cam_pkg::cor_req_t  req,
  output cam_pkg::cor_rsp_t  rsp
);
  import cam_pkg::*;

  localparam int IW = $clog2(ATAN_ENTRIES);

  logic                     busy;
  logic                     done;
  logic [IW-1:0]            idx;
  logic signed [CORD_W-1:0] x;
  logic signed [CORD_W-1:0] y;
  logic signed [ZW-1:0]     z;
  logic                     neg;
  logic signed [CORD_W-1:0] xo;
  logic signed [CORD_W-1:0] yo;

  logic signed [32:0]       ang_ext;
  logic signed [32:0]       fold;
  logic                     fold_neg;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [ZW-1:0]     at;
  logic signed [CORD_W-1:0] x_next;
  logic signed [CORD_W-1:0] y_next;
  logic signed [ZW-1:0]     z_next;

  // Fold angles beyond a quarter turn by a half turn; the result is negated.
  always_comb begin
    ang_ext  = 33'(req.angle);
    fold     = ang_ext;
    fold_neg = 1'b0;
    if (ang_ext > QUARTER_TURN) begin
      fold     = ang_ext - HALF_TURN;
      fold_neg = 1'b1;
    end else if (ang_ext < -QUARTER_TURN) begin
      fold     = ang_ext + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  // One micro-rotation.
  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = ZW'(atan_deg(5'(idx)));
    if (!z[ZW-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= fold[ZW-1:0];
        neg  <= fold_neg;
        idx  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x   <= x_next;
        y   <= y_next;
        z   <= z_next;
        idx <= idx + 1'b1;
        if (idx == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          xo   <= neg ? -x_next : x_next;
          yo   <= neg ? -y_next : y_next;
        end
      end
    end
  end

  always_comb begin
    rsp.done  = done;
    rsp.cos_v = xo;
    rsp.sin_v = yo;
  end

endmodule

// ===== hw/rtl/first_person_camera_update.sv =====
// Top level of the fly camera: sequencer, angle and vector state, square root and divider.
//
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+----------------------
//  input    | mouse_dx, mouse_dy, key bits              | in_valid / in_ready
//  output   | pos_x..z, dir_x..z, up_x..z               | out_valid / out_ready
//  config   | cfg_index, cfg_data                       | cfg_we, no wait
//
// The time per word depends on CORDIC_STEPS and on the held move keys. Much of it is the
// 4-bit-per-cycle multiplier (up to 26 products); the 32-step square root and 16-step
// divider run once per vector and component.
// Reset returns the angles, vectors and position to their home values.
// A finished word waits in the output register; the next word is taken meanwhile and
// is only held at the end if the previous one has not been taken.
module first_person_camera_update #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] mouse_dx,
  input  logic signed [15:0] mouse_dy,
  input  logic               fast_held,
  input  logic               reset_pressed,
  input  logic               move_forward,
  input  logic               move_back,
  input  logic               strafe_left,
  input  logic               strafe_right,
  input  logic               rise,
  input  logic               sink,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);
  import cam_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_YAW_MUL, ST_YAW_MOD, ST_PITCH_MUL, ST_COR_YAW, ST_COR_PITCH,
    ST_FRONT, ST_NORM_SEL, ST_NORM_SQ, ST_SQRT, ST_DIV_LOAD, ST_DIV,
    ST_DIV_STORE, ST_KEYS, ST_MOVE_SEL, ST_MOVE, ST_DONE
  } state_t;

  state_t state;
  logic   issue;

  // Configuration.
  logic [31:0] start_pos [3];
  logic [23:0] base_speed;
  logic [15:0] look_sens;

  // Camera state.
  logic [31:0]        pos [3];
  logic signed [31:0] yaw;
  logic signed [31:0] pitch;
  logic signed [15:0] dir [3];
  logic signed [15:0] rgt [3];
  logic signed [15:0] upv [3];

  // Latched input word.
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic               fast_q;
  logic               home_q;
  logic [2:0]         mv_add;
  logic [2:0]         mv_sub;

  // Working registers.
  logic [2:0]               step;
  logic [1:0]               k;
  logic [1:0]               vsel;
  logic [CNT_W-1:0]         cnt;
  logic [MODW-1:0]          w;
  logic [MODW-1:0]          md;
  logic signed [CORD_W-1:0] cy, sy, cp, sp;
  logic signed [MUL_W-1:0]  fx, fz;
  logic signed [MUL_W-1:0]  u [3];
  logic signed [MUL_W-1:0]  nv [3];
  logic signed [PROD_W-1:0] acc68;
  logic [63:0]              sum;
  logic [63:0]              sq_x, sq_res, sq_bit;
  logic [32:0]              len;
  logic [DVW-1:0]           dv_rem, dv_d;
  logic [15:0]              dv_q;
  logic [25:0]              speed;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  cor_req_t creq;
  cor_rsp_t crsp;

  cam_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  cam_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  // Combinational helpers.
  logic signed [PROD_W-1:0] prod, pr30, pr14, u1_sum;
  logic signed [MODW-1:0]   w_init;
  logic [MODW-1:0]          w_sub;
  logic signed [MUL_W-1:0]  p_new;
  logic signed [31:0]       p_clamp;
  logic [63:0]              sum_next;
  logic [64:0]              sq_t;
  logic                     sq_ge;
  logic [63:0]              sq_x_next, sq_res_next;
  logic                     dv_ge;
  logic signed [MUL_W-1:0]  nv_k;
  logic [MUL_W-1:0]         nv_mag;
  logic signed [15:0]       q_val;
  logic signed [15:0]       vec_k;
  logic                     mv_on;

  always_comb begin
    prod   = mrsp.prod;
    pr30   = prod >>> 30;
    pr14   = prod >>> 14;
    u1_sum = (acc68 + prod) >>> 30;

    // Yaw wrap and pitch clamp.
    w_init = MODW'(yaw) + MODW'(prod) + YAW_BIAS;
    w_sub  = (w >= md) ? w - md : w;
    p_new  = MUL_W'(pitch) - MUL_W'(prod);
    if (p_new > MUL_W'(PITCH_LIMIT)) begin
      p_clamp = 32'(PITCH_LIMIT);
    end else if (p_new < -MUL_W'(PITCH_LIMIT)) begin
      p_clamp = -32'(PITCH_LIMIT);
    end else begin
      p_clamp = p_new[31:0];
    end

    // Square root step.
    sum_next    = sum + prod[63:0];
    sq_t        = {1'b0, sq_res} + {1'b0, sq_bit};
    sq_ge       = {1'b0, sq_x} >= sq_t;
    sq_x_next   = sq_ge ? sq_x - sq_t[63:0] : sq_x;
    sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

    // Divider step and result saturation.
    dv_ge  = dv_rem >= dv_d;
    nv_k   = nv[k];
    nv_mag = nv_k[MUL_W-1] ? MUL_W'(-nv_k) : MUL_W'(nv_k);
    if (dv_q[15]) begin
      q_val = nv_k[MUL_W-1] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      q_val = nv_k[MUL_W-1] ? -$signed({1'b0, dv_q[14:0]}) : $signed({1'b0, dv_q[14:0]});
    end

    // Move vector component and whether that vector moves at all.
    case (vsel)
      2'd0:    vec_k = dir[k];
      2'd1:    vec_k = rgt[k];
      default: vec_k = upv[k];
    endcase
    mv_on = (vsel != 2'd3) && (mv_add[vsel] ^ mv_sub[vsel]);
  end

  // Multiplier and CORDIC requests.
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    case (state)
      ST_YAW_MUL: begin
        mreq.start = issue;
        mreq.a     = MUL_W'(dx);
        mreq.b     = MUL_W'({1'b0, look_sens});
      end
      ST_PITCH_MUL: begin
        mreq.start = issue;
        mreq.a     = MUL_W'(dy);
        mreq.b     = MUL_W'({1'b0, look_sens});
      end
      ST_FRONT: begin
        mreq.start = issue;
        case (step)
          3'd0:    begin mreq.a = cy;  mreq.b = cp; end
          3'd1:    begin mreq.a = sy;  mreq.b = cp; end
          3'd2:    begin mreq.a = -fx; mreq.b = sp; end
          3'd3:    begin mreq.a = fx;  mreq.b = fx; end
          3'd4:    begin mreq.a = fz;  mreq.b = fz; end
          default: begin mreq.a = -fz; mreq.b = sp; end
        endcase
      end
      ST_NORM_SQ: begin
        mreq.start = issue;
        mreq.a     = nv_k;
        mreq.b     = nv_k;
      end
      ST_MOVE: begin
        mreq.start = issue;
        mreq.a     = MUL_W'(vec_k);
        mreq.b     = MUL_W'(speed);
      end
      default: ;
    endcase
    creq.start = issue && ((state == ST_COR_YAW) || (state == ST_COR_PITCH));
    creq.angle = (state == ST_COR_YAW) ? yaw : pitch;
  end

  assign in_ready = (state == ST_IDLE);

  // Sequencer, camera state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue      <= 1'b0;
      out_valid  <= 1'b0;
      start_pos  <= '{32'd0, 32'd0, 32'd0};
      base_speed <= 24'd6554;
      look_sens  <= 16'd6554;
      pos        <= '{32'd0, 32'd0, 32'd0};
      yaw        <= -32'(QUARTER_TURN);
      pitch      <= '0;
      dir        <= '{16'sd0, 16'sd0, -ONE_Q14};
      rgt        <= '{ONE_Q14, 16'sd0, 16'sd0};
      upv        <= '{16'sd0, ONE_Q14, 16'sd0};
    end else begin
      issue <= 1'b0;

      // Register writes.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_X:  start_pos[0] <= cfg_data;
          REG_START_Y:  start_pos[1] <= cfg_data;
          REG_START_Z:  start_pos[2] <= cfg_data;
          REG_BASE_SPD: base_speed   <= cfg_data[23:0];
          REG_LOOK_SNS: look_sens    <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dx     <= mouse_dx;
            dy     <= mouse_dy;
            fast_q <= fast_held;
            home_q <= reset_pressed;
            mv_add <= {rise, strafe_right, move_forward};
            mv_sub <= {sink, strafe_left, move_back};
            issue  <= 1'b1;
            state  <= ST_YAW_MUL;
          end
        end
        ST_YAW_MUL: begin
          if (mrsp.done) begin
            w     <= MODW'(w_init);
            md    <= MOD_TOP;
            cnt   <= '0;
            state <= ST_YAW_MOD;
          end
        end
        // Reduce modulo one turn, one restoring step per cycle.
        ST_YAW_MOD: begin
          w   <= w_sub;
          md  <= md >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MOD_STEPS - 1)) begin
            yaw   <= 32'(w_sub - MODW'(HALF_TURN));
            issue <= 1'b1;
            state <= ST_PITCH_MUL;
          end
        end
        ST_PITCH_MUL: begin
          if (mrsp.done) begin
            pitch <= p_clamp;
            issue <= 1'b1;
            state <= ST_COR_YAW;
          end
        end
        ST_COR_YAW: begin
          if (crsp.done) begin
            cy    <= crsp.cos_v;
            sy    <= crsp.sin_v;
            issue <= 1'b1;
            state <= ST_COR_PITCH;
          end
        end
        ST_COR_PITCH: begin
          if (crsp.done) begin
            cp    <= crsp.cos_v;
            sp    <= crsp.sin_v;
            step  <= '0;
            issue <= 1'b1;
            state <= ST_FRONT;
          end
        end
        // Front vector and the unnormalized up vector.
        ST_FRONT: begin
          if (mrsp.done) begin
            case (step)
              3'd0:    fx    <= pr30[MUL_W-1:0];
              3'd1:    fz    <= pr30[MUL_W-1:0];
              3'd2:    u[0]  <= pr30[MUL_W-1:0];
              3'd3:    acc68 <= prod;
              3'd4:    u[1]  <= u1_sum[MUL_W-1:0];
              default: u[2]  <= pr30[MUL_W-1:0];
            endcase
            if (step == 3'd5) begin
              vsel  <= '0;
              state <= ST_NORM_SEL;
            end else begin
              step  <= step + 1'b1;
              issue <= 1'b1;
            end
          end
        end
        // Pick the vector to normalize: front, right, then up.
        ST_NORM_SEL: begin
          if (vsel == 2'd3) begin
            state <= ST_KEYS;
          end else begin
            case (vsel)
              2'd0: begin
                nv[0] <= fx;
                nv[1] <= MUL_W'(sp);
                nv[2] <= fz;
              end
              2'd1: begin
                nv[0] <= -fz;
                nv[1] <= '0;
                nv[2] <= fx;
              end
              default: nv <= u;
            endcase
            sum   <= '0;
            k     <= '0;
            issue <= 1'b1;
            state <= ST_NORM_SQ;
          end
        end
        ST_NORM_SQ: begin
          if (mrsp.done) begin
            if (k == 2'd2) begin
              sq_x   <= sum_next;
              sq_res <= '0;
              sq_bit <= 64'h4000_0000_0000_0000;
              cnt    <= '0;
              state  <= ST_SQRT;
            end else begin
              sum   <= sum_next;
              k     <= k + 1'b1;
              issue <= 1'b1;
            end
          end
        end
        // Floor square root, one result bit per cycle.
        ST_SQRT: begin
          sq_x   <= sq_x_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            len <= sq_res_next[32:0];
            k   <= '0;
            if (sq_res_next == '0) begin
              vsel  <= vsel + 1'b1;
              state <= ST_NORM_SEL;
            end else begin
              state <= ST_DIV_LOAD;
            end
          end
        end
        // Rounded quotient |c| * 2^14 / len.
        ST_DIV_LOAD: begin
          dv_rem <= DVW'({nv_mag, 14'b0}) + DVW'(len >> 1);
          dv_d   <= DVW'({len, 15'b0});
          dv_q   <= '0;
          cnt    <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (dv_ge) begin
            dv_rem <= dv_rem - dv_d;
          end
          dv_q <= {dv_q[14:0], dv_ge};
          dv_d <= dv_d >> 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_DIV_STORE;
          end
        end
        ST_DIV_STORE: begin
          case (vsel)
            2'd0:    dir[k] <= q_val;
            2'd1:    rgt[k] <= q_val;
            default: upv[k] <= q_val;
          endcase
          if (k == 2'd2) begin
            vsel  <= vsel + 1'b1;
            state <= ST_NORM_SEL;
          end else begin
            k     <= k + 1'b1;
            state <= ST_DIV_LOAD;
          end
        end
        // Home key and speed for this word.
        ST_KEYS: begin
          if (home_q) begin
            dir <= '{16'sd0, 16'sd0, -ONE_Q14};
            pos <= start_pos;
          end
          speed <= fast_q ? 26'(base_speed) + 26'({base_speed, 1'b0}) : 26'(base_speed);
          vsel  <= '0;
          state <= ST_MOVE_SEL;
        end
        // Opposite keys on one vector cancel exactly, so only a lone key moves.
        ST_MOVE_SEL: begin
          if (vsel == 2'd3) begin
            state <= ST_DONE;
          end else if (mv_on) begin
            k     <= '0;
            issue <= 1'b1;
            state <= ST_MOVE;
          end else begin
            vsel <= vsel + 1'b1;
          end
        end
        ST_MOVE: begin
          if (mrsp.done) begin
            pos[k] <= mv_add[vsel] ? pos[k] + pr14[31:0] : pos[k] - pr14[31:0];
            if (k == 2'd2) begin
              vsel  <= vsel + 1'b1;
              state <= ST_MOVE_SEL;
            end else begin
              k     <= k + 1'b1;
              issue <= 1'b1;
            end
          end
        end
        // Hand the word to the output register once it is free.
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x     <= pos[0];
            pos_y     <= pos[1];
            pos_z     <= pos[2];
            dir_x     <= dir[0];
            dir_y     <= dir[1];
            dir_z     <= dir[2];
            up_x      <= upv[0];
            up_y      <= upv[1];
            up_z      <= upv[2];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cam_checker.sv =====
// Port-level checks for the camera update block, bound to the top level.
module cam_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] up_x
);

  // A held output word keeps its value until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(dir_x) && $stable(up_x))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The block works on one word at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

  // A result never appears in the cycle right after a word is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind first_person_camera_update cam_checker u_cam_checker (.*);
